/* sv/selective_repeat_retransmit_window_unit_assert.svh */
// assertion macros for the retransmit window unit
`ifndef SELECTIVE_REPEAT_RETRANSMIT_WINDOW_UNIT_ASSERT_SVH
`define SELECTIVE_REPEAT_RETRANSMIT_WINDOW_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SRW_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SRW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/srw_pkg.sv */
// shared types, codes and defaults for the retransmit window unit
`timescale 1ns / 1ps

package srw_pkg;

	localparam int WINDOW_MAX_DEF = 16;

	localparam logic [4:0]  WINDOW_SIZE_RST = 5'd16;
	localparam logic [31:0] TIMEOUT_RST     = 32'd1000;
	localparam logic [31:0] FIRST_SEQ_RST   = 32'd0;

	// operation codes
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_POLL = 2'd1;
	localparam logic [1:0] OP_ACK  = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	// status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_RANGE = 2'd2;
	localparam logic [1:0] STS_EMPTY = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_WINDOW_SIZE = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT     = 2'd1;
	localparam logic [1:0] CFG_FIRST_SEQ   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_POLL_SCAN,
		ST_ACK_CHECK,
		ST_ACK_FREE,
		ST_DONE
	} srw_state_t;

	// result of the shared subtract and compare unit
	typedef struct packed {
		logic        borrow;
		logic        ge;
		logic [31:0] diff;
	} alu_res_t;

endpackage

/* sv/selective_repeat_retransmit_window_unit.sv */
// top level: selective-repeat retransmission window with slot-serial sequencer
// One item at a time. An item is taken only when the sequencer is idle and walks
// the window one slot per cycle through a slot store with one write port and a
// registered read, and one shared subtract/compare unit. Add scans for a free
// slot, poll scans for an aged packet (the store read is registered), ack runs
// one check step and then a freeing pass; each item then loads the output
// register in the done state and returns to idle to take the next beat. A stalled
// result holds the sequencer in its last state. The output register lets a
// finished result wait while the next item is accepted. No clearing pass is
// needed after reset: slot occupancy lives in flip-flops cleared by reset.
`timescale 1ns / 1ps
`include "selective_repeat_retransmit_window_unit_assert.svh"

module selective_repeat_retransmit_window_unit
	import srw_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [15:0] packet_handle,
	input  logic [31:0] acked_seq,
	input  logic [31:0] now_time,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        retransmit_valid,
	output logic [15:0] retransmit_handle,
	output logic [3:0]  retransmit_slot,
	output logic        ready_for_new,
	output logic [4:0]  occupancy,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
	localparam logic [31:0] WMAX32 = 32'(WINDOW_MAX);

	srw_state_t state_q, state_d;

	// configuration and window state
	logic [4:0]            window_size_q;
	logic [31:0]           timeout_q;
	logic [WINDOW_MAX-1:0] slot_valid_q;
	logic [CNT_W-1:0]      count_q;
	logic [SLOT_W-1:0]     start_q;
	logic [31:0]           next_exp_q;

	// captured item
	logic [15:0] handle_q;
	logic [31:0] ack_q;
	logic [31:0] now_q;

	// scan bookkeeping
	logic [SLOT_W-1:0] idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  d_q;
	logic              pend_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              last_s1;
	logic              vld_s1;

	// result being built, and the output register
	logic [1:0]  res_status_q;
	logic        res_rv_q;
	logic [15:0] res_rh_q;
	logic [3:0]  res_rs_q;
	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic        out_rv_q;
	logic [15:0] out_rh_q;
	logic [3:0]  out_rs_q;
	logic        out_ready_q;
	logic [4:0]  out_occ_q;

	logic [CNT_W-1:0]  w_eff;
	logic [CNT_W-1:0]  idx_inc;
	logic [SLOT_W-1:0] idx_next;
	logic              last;
	logic              cur_valid;
	logic              in_acc;
	logic              cfg_acc;
	logic              out_free;
	logic              poll_hit;
	logic              poll_end;
	logic              ack_range;

	logic [31:0]  alu_a, alu_b, alu_c;
	alu_res_t     alu;

	logic              mem_we_handle, mem_we_time;
	logic [SLOT_W-1:0] mem_waddr;
	logic [15:0]       mem_rd_handle;
	logic [31:0]       mem_rd_time;

	// effective window: zero acts as one, clipped at the built depth
	always_comb begin
		if (window_size_q == 5'd0) begin
			w_eff = CNT_W'(1);
		end else if ({27'd0, window_size_q} > WMAX32) begin
			w_eff = CNT_W'(WINDOW_MAX);
		end else begin
			w_eff = CNT_W'(window_size_q);
		end
	end

	always_comb begin
		idx_inc   = CNT_W'(idx_q) + CNT_W'(1);
		idx_next  = (idx_inc == w_eff) ? '0 : SLOT_W'(idx_inc);
		last      = ((cnt_q + CNT_W'(1)) == w_eff);
		cur_valid = slot_valid_q[idx_q];
		in_acc    = in_valid && !in_stall;
		cfg_acc   = cfg_valid && cfg_ready;
		out_free  = !out_valid_q || !out_stall;
		poll_hit  = (state_q == ST_POLL_SCAN) && pend_s1 && vld_s1 && alu.ge;
		poll_end  = pend_s1 && ((vld_s1 && alu.ge) || last_s1);
		ack_range = !alu.borrow && alu.ge;
	end

	srw_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.c   (alu_c),
		.res (alu)
	);

	srw_slot_mem #(
		.DEPTH  (WINDOW_MAX),
		.ADDR_W (SLOT_W)
	) u_mem (
		.clk       (clk),
		.we_handle (mem_we_handle),
		.we_time   (mem_we_time),
		.wr_addr   (mem_waddr),
		.wr_handle (handle_q),
		.wr_time   (now_q),
		.rd_addr   (idx_q),
		.rd_handle (mem_rd_handle),
		.rd_time   (mem_rd_time)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (operation)
						OP_ADD:  state_d = ST_ADD_SCAN;
						OP_POLL: state_d = (count_q == '0) ? ST_DONE : ST_POLL_SCAN;
						OP_ACK:  state_d = ST_ACK_CHECK;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_ADD_SCAN: begin
				if (!cur_valid || last) state_d = ST_DONE;
			end
			ST_POLL_SCAN: begin
				if (poll_end) state_d = ST_DONE;
			end
			ST_ACK_CHECK: begin
				if (ack_range || count_q == '0 || alu.borrow) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_ACK_FREE;
				end
			end
			ST_ACK_FREE: begin
				if (cnt_q == d_q) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		cfg_ready     = (state_q == ST_IDLE);
		mem_we_handle = (state_q == ST_ADD_SCAN) && !cur_valid;
		mem_we_time   = mem_we_handle || poll_hit;
		mem_waddr     = (state_q == ST_ADD_SCAN) ? idx_q : idx_s1;
		if (state_q == ST_POLL_SCAN) begin
			// packet age against the timeout
			alu_a = now_q;
			alu_b = mem_rd_time;
			alu_c = timeout_q;
		end else begin
			// acked number against the expected one and the window
			alu_a = ack_q;
			alu_b = next_exp_q;
			alu_c = 32'(w_eff);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_size_q <= WINDOW_SIZE_RST;
			timeout_q     <= TIMEOUT_RST;
			slot_valid_q  <= '0;
			count_q       <= '0;
			start_q       <= '0;
			next_exp_q    <= FIRST_SEQ_RST;
			pend_s1       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			unique case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
				end
				ST_ADD_SCAN: begin
					if (!cur_valid) begin
						slot_valid_q[idx_q] <= 1'b1;
						count_q             <= count_q + CNT_W'(1);
					end
				end
				ST_POLL_SCAN: begin
					// issue the next slot read unless this cycle finishes the scan
					pend_s1 <= !poll_end;
				end
				ST_ACK_CHECK: begin
				end
				ST_ACK_FREE: begin
					if (cur_valid) begin
						slot_valid_q[idx_q] <= 1'b0;
						count_q             <= count_q - CNT_W'(1);
					end
					if (cnt_q == d_q) begin
						start_q    <= idx_next;
						next_exp_q <= ack_q + 32'd1;
					end
				end
				ST_DONE: begin
				end
				default: begin
				end
			endcase

			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_acc) begin
				unique case (cfg_index)
					CFG_WINDOW_SIZE: begin
						// resizing drops everything in flight
						window_size_q <= cfg_data[4:0];
						slot_valid_q  <= '0;
						count_q       <= '0;
						start_q       <= '0;
					end
					CFG_TIMEOUT:   timeout_q  <= cfg_data;
					CFG_FIRST_SEQ: next_exp_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					handle_q     <= packet_handle;
					ack_q        <= acked_seq;
					now_q        <= now_time;
					idx_q        <= start_q;
					cnt_q        <= '0;
					res_rv_q     <= 1'b0;
					res_rh_q     <= '0;
					res_rs_q     <= '0;
					res_status_q <= (operation == OP_POLL && count_q == '0) ? STS_EMPTY : STS_OK;
				end
			end
			ST_ADD_SCAN: begin
				if (cur_valid) begin
					idx_q <= idx_next;
					cnt_q <= cnt_q + CNT_W'(1);
					if (last) res_status_q <= STS_FULL;
				end
			end
			ST_POLL_SCAN: begin
				if (poll_hit) begin
					res_rv_q <= 1'b1;
					res_rh_q <= mem_rd_handle;
					res_rs_q <= 4'(idx_s1);
				end
				idx_s1  <= idx_q;
				last_s1 <= last;
				vld_s1  <= cur_valid;
				idx_q   <= idx_next;
				cnt_q   <= cnt_q + CNT_W'(1);
			end
			ST_ACK_CHECK: begin
				d_q <= alu.diff[CNT_W-1:0];
				if (ack_range) begin
					res_status_q <= STS_RANGE;
				end else if (count_q == '0) begin
					res_status_q <= STS_EMPTY;
				end
			end
			ST_ACK_FREE: begin
				idx_q <= idx_next;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_rv_q     <= res_rv_q;
					out_rh_q     <= res_rh_q;
					out_rs_q     <= res_rs_q;
					out_ready_q  <= (count_q < w_eff);
					out_occ_q    <= 5'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid         = out_valid_q;
	assign status            = out_status_q;
	assign retransmit_valid  = out_rv_q;
	assign retransmit_handle = out_rh_q;
	assign retransmit_slot   = out_rs_q;
	assign ready_for_new     = out_ready_q;
	assign occupancy         = out_occ_q;

	`SRW_ASSERT_NOW(a_count_matches_valid, clk, arst_n, 1'b1,
		$countones(slot_valid_q) == count_q, "stored count disagrees with slot occupancy")
	`SRW_ASSERT_NOW(a_count_in_window, clk, arst_n, 1'b1,
		count_q <= w_eff, "stored count exceeds the window")
	`SRW_ASSERT_NOW(a_start_in_window, clk, arst_n, 1'b1,
		CNT_W'(start_q) < w_eff, "window start outside the window")
	`SRW_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, in_acc,
		state_q != ST_IDLE, "accepted beat did not start the sequencer")

endmodule

/* sv/srw_alu.sv */
// shared subtract and compare unit: a - b with borrow, and (a - b) mod 2^32 >= c
`timescale 1ns / 1ps

module srw_alu
	import srw_pkg::*;
(
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	output alu_res_t    res
);

	logic [32:0] diff33;

	always_comb begin
		diff33     = {1'b0, a} - {1'b0, b};
		res.borrow = diff33[32];
		res.diff   = diff33[31:0];
		res.ge     = (diff33[31:0] >= c);
	end

endmodule

/* sv/srw_slot_mem.sv */
// slot store: packet handle and send time per slot, one write port, registered read
`timescale 1ns / 1ps

module srw_slot_mem
	import srw_pkg::*;
#(
	parameter int DEPTH  = WINDOW_MAX_DEF,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we_handle,
	input  logic              we_time,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [15:0]       wr_handle,
	input  logic [31:0]       wr_time,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [15:0]       rd_handle,
	output logic [31:0]       rd_time
);

	logic [15:0] handle_mem [DEPTH];
	logic [31:0] time_mem   [DEPTH];
	logic [15:0] rd_handle_q;
	logic [31:0] rd_time_q;

	always_ff @(posedge clk) begin
		if (we_handle) begin
			handle_mem[wr_addr] <= wr_handle;
		end
		if (we_time) begin
			time_mem[wr_addr] <= wr_time;
		end
		rd_handle_q <= handle_mem[rd_addr];
		rd_time_q   <= time_mem[rd_addr];
	end

	assign rd_handle = rd_handle_q;
	assign rd_time   = rd_time_q;

endmodule

/* sim/testbench.sv */
// self-checking testbench for the selective-repeat retransmission window unit
`timescale 1ns / 1ps

module testbench;
	import srw_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic        retx;
		logic [15:0] tag;
		logic [3:0]  slot;
		logic        ready;
		logic [4:0]  occ;
	} window_result_t;

	// tracks the window contents and holds the results still owed by the block
	class retx_window_scoreboard;
		bit [4:0]  size_reg;
		bit [31:0] timeout_reg;
		bit [31:0] first_seq_reg;
		bit        slot_busy[WINDOW_MAX_DEF];
		bit [15:0] slot_tag[WINDOW_MAX_DEF];
		bit [31:0] slot_stamp[WINDOW_MAX_DEF];
		int unsigned base;
		bit [31:0] next_seq;
		int unsigned count;
		window_result_t owed_q[$];
		int unsigned errors, items, results, n_full, n_retx, n_range, n_empty;

		function new();
			size_reg      = WINDOW_SIZE_RST;
			timeout_reg   = TIMEOUT_RST;
			first_seq_reg = FIRST_SEQ_RST;
			flush();
			next_seq = first_seq_reg;
		endfunction

		function void flush();
			foreach (slot_busy[i])
				slot_busy[i] = 1'b0;
			base  = 0;
			count = 0;
		endfunction

		// slots in use, with zero and oversize values clamped
		function int unsigned span();
			if (size_reg == 0)
				return 1;
			if (size_reg > WINDOW_MAX_DEF)
				return WINDOW_MAX_DEF;
			return size_reg;
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction

		function void write_register(logic [1:0] idx, logic [31:0] data);
			case (idx)
				CFG_WINDOW_SIZE: begin
					size_reg = data[4:0];
					flush();
				end
				CFG_TIMEOUT: timeout_reg = data;
				CFG_FIRST_SEQ: begin
					first_seq_reg = data;
					next_seq      = data;
				end
				default: ;
			endcase
		endfunction

		function void note_item(logic [1:0] op, logic [15:0] tag, logic [31:0] acked,
				logic [31:0] now);
			window_result_t r;
			int unsigned w, idx, adv;
			bit [31:0] age;
			longint unsigned nx, ak;
			w = span();
			r = '0;
			items++;
			case (op)
				OP_ADD: begin
					r.status = STS_FULL;
					for (int unsigned i = 0; i < w; i++) begin
						idx = (base + i) % w;
						if (!slot_busy[idx]) begin
							slot_busy[idx]  = 1'b1;
							slot_tag[idx]   = tag;
							slot_stamp[idx] = now;
							count++;
							r.status = STS_OK;
							break;
						end
					end
				end
				OP_POLL: begin
					if (count == 0)
						r.status = STS_EMPTY;
					else
						for (int unsigned i = 0; i < w; i++) begin
							idx = (base + i) % w;
							age = now - slot_stamp[idx];
							if (slot_busy[idx] && age >= timeout_reg) begin
								slot_stamp[idx] = now;
								r.retx = 1'b1;
								r.tag  = slot_tag[idx];
								r.slot = idx[3:0];
								break;
							end
						end
				end
				OP_ACK: begin
					nx = next_seq;
					ak = acked;
					// range test is done without wrap and ahead of the empty test
					if (ak >= nx + w)
						r.status = STS_RANGE;
					else if (count == 0)
						r.status = STS_EMPTY;
					else begin
						for (int unsigned i = 0; i < w; i++) begin
							idx = (base + i) % w;
							if (nx + i <= ak && slot_busy[idx]) begin
								slot_busy[idx] = 1'b0;
								count--;
							end
						end
						if (ak >= nx) begin
							adv      = 32'((ak + 1 - nx) % w);
							base     = (base + adv) % w;
							next_seq = acked + 32'd1;
						end
					end
				end
				default: ;
			endcase
			r.ready = (count < w);
			r.occ   = count[4:0];
			if (r.status == STS_FULL)
				n_full++;
			if (r.status == STS_RANGE)
				n_range++;
			if (r.status == STS_EMPTY)
				n_empty++;
			if (r.retx)
				n_retx++;
			owed_q.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= 30)
					$display("%0t: %s mismatch, expected %0h, actual %0h",
						$time, name, want, got);
			end
		endfunction

		function void check_result(window_result_t got);
			window_result_t want;
			results++;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= 30)
					$display("%0t: result beat with nothing owed, expected none, actual %h",
						$time, got);
				return;
			end
			want = owed_q.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("retransmit_valid", want.retx, got.retx);
			compare_field("retransmit_handle", want.tag, got.tag);
			compare_field("retransmit_slot", want.slot, got.slot);
			compare_field("ready_for_new", want.ready, got.ready);
			compare_field("occupancy", want.occ, got.occ);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = OP_NOP;
	logic [15:0] packet_handle = '0;
	logic [31:0] acked_seq = '0;
	logic [31:0] now_time = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        retransmit_valid;
	logic [15:0] retransmit_handle;
	logic [3:0]  retransmit_slot;
	logic        ready_for_new;
	logic [4:0]  occupancy;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_WINDOW_SIZE;
	logic [31:0] cfg_data = '0;

	retx_window_scoreboard sb = new();
	bit          idle_enable = 1'b1;
	bit [31:0]   tick;
	int unsigned settings_used;

	selective_repeat_retransmit_window_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.packet_handle    (packet_handle),
		.acked_seq        (acked_seq),
		.now_time         (now_time),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.retransmit_valid (retransmit_valid),
		.retransmit_handle(retransmit_handle),
		.retransmit_slot  (retransmit_slot),
		.ready_for_new    (ready_for_new),
		.occupancy        (occupancy),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #10 clk = ~clk;

	// result side: check each accepted beat, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({status, retransmit_valid, retransmit_handle, retransmit_slot,
				ready_for_new, occupancy});
		out_stall <= idle_enable && ($urandom_range(99) < 11);
	end

	task automatic send_item(input logic [1:0] op, input logic [15:0] tag,
			input logic [31:0] acked, input logic [31:0] now);
		while (idle_enable && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		packet_handle <= tag;
		acked_seq     <= acked;
		now_time      <= now;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_item(op, tag, acked, now);
	endtask

	// stop sending and let every owed result come back, plus the scan latency
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (WINDOW_MAX_DEF + 4)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_register(idx, data);
	endtask

	task automatic configure(input logic [4:0] size, input logic [31:0] timeout,
			input logic [31:0] first_seq);
		drain();
		write_reg(CFG_FIRST_SEQ, first_seq);
		write_reg(CFG_TIMEOUT, timeout);
		write_reg(CFG_WINDOW_SIZE, {27'd0, size});
		cfg_valid <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// mostly well-formed traffic around the current window, some noise
	task automatic random_item();
		int unsigned r, w;
		logic [31:0] ack;
		w    = sb.span();
		tick = tick + $urandom_range(0, 400);
		r    = $urandom_range(99);
		if (r < 40)
			send_item(OP_ADD, 16'($urandom), $urandom, tick);
		else if (r < 65)
			send_item(OP_POLL, 16'($urandom), $urandom, tick);
		else if (r < 92) begin
			case ($urandom_range(9))
				0: ack = sb.next_seq - $urandom_range(1, 4);
				1: ack = sb.next_seq + w + $urandom_range(0, 3);
				2, 3, 4: ack = sb.next_seq + $urandom_range(0, w - 1);
				default: ack = sb.next_seq + $urandom_range(0, (w - 1) / 4);
			endcase
			send_item(OP_ACK, 16'($urandom), ack, tick);
		end else if (r < 96)
			send_item(OP_NOP, 16'($urandom), $urandom, $urandom);
		else
			send_item(2'($urandom_range(3)), 16'($urandom), $urandom, $urandom);
	endtask

	initial begin
		logic [4:0]  phase_size[6];
		logic [31:0] phase_timeout[6];
		logic [31:0] phase_first[6];
		phase_size    = '{5'd16, 5'd4, 5'd31, 5'($urandom_range(1, 16)), 5'd0, 5'd8};
		phase_timeout = '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'($urandom_range(1, 3000)),
			32'd50, 32'd200};
		phase_first   = '{$urandom, 32'hFFFF_FFF8, 32'd0, $urandom, $urandom, 32'hFFFF_FFFC};
		settings_used = 1;

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: empty window, range before empty, age wrap
		send_item(OP_POLL, 16'h0, 32'd0, 32'd0);
		send_item(OP_ACK, 16'h0, 32'd0, 32'd0);
		send_item(OP_ACK, 16'h0, 32'd16, 32'd0);
		send_item(OP_ADD, 16'h0000, 32'd0, 32'd0);
		send_item(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_POLL, 16'h0, 32'd0, 32'd500);
		send_item(OP_POLL, 16'h0, 32'd0, 32'd1000);
		send_item(OP_NOP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_ACK, 16'h0, 32'd0, 32'd1000);
		send_item(OP_ACK, 16'h0, 32'd0, 32'd1000);
		send_item(OP_ACK, 16'h0, 32'hFFFF_FFFF, 32'd0);

		// single slot, zero timeout, sequence wrapping past the top
		configure(5'd1, 32'd0, 32'hFFFF_FFFF);
		send_item(OP_ADD, 16'h1234, 32'd0, 32'd77);
		send_item(OP_ADD, 16'h4321, 32'd0, 32'd78);
		send_item(OP_POLL, 16'h0, 32'd0, 32'd78);
		send_item(OP_ACK, 16'h0, 32'hFFFF_FFFF, 32'd79);
		send_item(OP_ADD, 16'h5A5A, 32'd0, 32'd80);
		send_item(OP_ACK, 16'h0, 32'd0, 32'd81);

		// zero size acts as one; largest timeout needs the largest age
		configure(5'd0, 32'hFFFF_FFFF, $urandom);
		send_item(OP_ADD, 16'hA5A5, 32'd0, 32'd5);
		send_item(OP_POLL, 16'h0, 32'd0, 32'd4);
		send_item(OP_POLL, 16'h0, 32'd0, 32'd4);

		for (int p = 0; p < 6; p++) begin
			configure(phase_size[p], phase_timeout[p], phase_first[p]);
			tick = $urandom;
			// one long stretch with neither side idling
			idle_enable = (p != 2);
			for (int n = 0; n < 67; n++) begin
				if (p == 3 && n == 30)
					drain();
				random_item();
			end
		end
		idle_enable = 1'b1;

		drain();
		$display("covered %0d items and %0d results over %0d register settings",
			sb.items, sb.results, settings_used);
		$display("window full %0d, resends %0d, acks out of range %0d, nothing pending %0d",
			sb.n_full, sb.n_retx, sb.n_range, sb.n_empty);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results still owed", sb.pending());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
